FILE: rtl/core/websocket_frame_parser_unmasker_core_defines.svh
// assertion macros shared by the rtl
`ifndef WEBSOCKET_FRAME_PARSER_UNMASKER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_UNMASKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSFPU_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSFPU_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WSFPU_ASSERT(name, clk, rst, prop, msg)
`define WSFPU_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif

`endif

FILE: rtl/core/wsfpu_pkg.sv
`default_nettype none

package wsfpu_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 64;
  localparam logic [31:0] MAX_MESSAGE_RESET = 32'd1048576;

  localparam int LEN16_BYTES = 2;
  localparam int LEN64_BYTES = 8;
  localparam int MASK_BYTES  = 4;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [7:0] HDR_FIN_BIT   = 8'b1000_0000;
  localparam logic [7:0] HDR_RSV_BITS  = 8'b0111_0000;
  localparam logic [7:0] HDR_MASK_BIT  = 8'b1000_0000;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RESERVED = 3'd1;
  localparam logic [2:0] ERR_UNMASKED = 3'd2;
  localparam logic [2:0] ERR_OPCODE   = 3'd3;
  localparam logic [2:0] ERR_SEGMENT  = 3'd4;
  localparam logic [2:0] ERR_SIZE     = 3'd5;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_LEN16,
    PH_LEN64,
    PH_MASK,
    PH_BODY,
    PH_STUCK
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic [3:0] message_opcode;
    logic       is_control;
    logic       frame_end;
    logic       message_end;
    logic [2:0] error_code;
  } result_t;

  function automatic logic opcode_control(input logic [3:0] op);
    logic r;
    r = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    return r;
  endfunction

  function automatic logic opcode_known(input logic [3:0] op);
    logic r;
    r = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) || opcode_control(op);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/websocket_frame_parser_unmasker_core.sv
// channel   signals                      beat
// item      item_valid / item_stall      wsfpu_pkg::item_t   (mode, data_byte)
// result    result_valid / result_stall  wsfpu_pkg::result_t (one per item beat)
// config    cfg_write / cfg_data         max_message_bytes, 32 bit
//
// one item beat per cycle while item_stall is low, its result beat shows in the next cycle from the result register
// all parsing is one level of compare, counter and xor logic; the widest path is the
// message_total plus frame_length add and compare against max_message_bytes
// rst is synchronous, active high, clears parse state and sets max_message_bytes to 1048576
// item_stall is high only while a result beat waits and result_stall is high

`default_nettype none

`include "websocket_frame_parser_unmasker_core_defines.svh"

module websocket_frame_parser_unmasker_core #(
  parameter int LENGTH_WIDTH = wsfpu_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output      logic               item_stall,
  input  wire wsfpu_pkg::item_t   item,
  output      logic               result_valid,
  input  wire logic               result_stall,
  output      wsfpu_pkg::result_t result,
  input  wire logic               cfg_write,
  input  wire logic [31:0]        cfg_data
);

  localparam int LW = LENGTH_WIDTH;

  wsfpu_pkg::phase_t phase, phase_next;
  logic [7:0]        first_header_byte, first_header_byte_next;
  logic [LW-1:0]     frame_length, frame_length_next;
  logic              len_over, len_over_next;
  logic [LW-1:0]     byte_count, byte_count_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [LW-1:0]     message_total, message_total_next;
  logic              message_open, message_open_next;
  logic [3:0]        message_type, message_type_next;
  logic [2:0]        err_latched, err_latched_next;
  logic [31:0]       max_message_bytes;
  wsfpu_pkg::result_t result_next;

  logic          accept;
  logic [7:0]    b;
  logic [6:0]    len7;
  logic [3:0]    op;
  logic          ctrl;
  logic [2:0]    head_err;
  logic [LW+7:0] len_shift;
  logic          len_shift_over;
  logic [LW-1:0] byte_count_inc;
  logic          len_done;
  logic          len_too_big;
  logic [LW:0]   total_sum;
  logic          total_too_big;
  logic          mask_done;
  logic          body_last;
  logic [1:0]    key_sel;
  logic [31:0]   mask_key_upd;
  logic [2:0]    err;
  logic          new_err;
  logic          fend;
  logic          msg_done;
  logic          type_set;

  assign accept     = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;

  // shared datapath terms
  always_comb begin
    b              = item.data_byte;
    len7           = b[6:0];
    op             = first_header_byte[3:0];
    ctrl           = wsfpu_pkg::opcode_control(op);
    len_shift      = {frame_length, b};
    len_shift_over = len_over || (|len_shift[LW+7:LW]);
    byte_count_inc = byte_count + LW'(1);
    len_done       = (phase == wsfpu_pkg::PH_LEN16) ?
                     (byte_count_inc >= LW'(wsfpu_pkg::LEN16_BYTES)) :
                     (byte_count_inc >= LW'(wsfpu_pkg::LEN64_BYTES));
    len_too_big    = len_shift_over || (len_shift[LW-1:0] > LW'(max_message_bytes));
    total_sum      = {1'b0, message_total} + {1'b0, frame_length};
    total_too_big  = total_sum > (LW+1)'(max_message_bytes);
    mask_done      = byte_count_inc >= LW'(wsfpu_pkg::MASK_BYTES);
    body_last      = byte_count_inc >= frame_length;
    key_sel        = byte_count[1:0];
    mask_key_upd   = mask_key;
    mask_key_upd[{key_sel, 3'b000} +: 8] = b;
  end

  // header checks, in priority order
  always_comb begin
    if ((first_header_byte & wsfpu_pkg::HDR_RSV_BITS) != 8'd0) begin
      head_err = wsfpu_pkg::ERR_RESERVED;
    end else if ((b & wsfpu_pkg::HDR_MASK_BIT) == 8'd0) begin
      head_err = wsfpu_pkg::ERR_UNMASKED;
    end else if (!wsfpu_pkg::opcode_known(op)) begin
      head_err = wsfpu_pkg::ERR_OPCODE;
    end else if (!ctrl && ((op != wsfpu_pkg::OP_CONT) == message_open)) begin
      head_err = wsfpu_pkg::ERR_SEGMENT;
    end else if (32'(len7) > max_message_bytes) begin
      head_err = wsfpu_pkg::ERR_SIZE;
    end else begin
      head_err = wsfpu_pkg::ERR_NONE;
    end
  end

  // error for this beat
  always_comb begin
    err = wsfpu_pkg::ERR_NONE;
    if (!item.mode) begin
      case (phase)
        wsfpu_pkg::PH_HEAD1: begin
          err = head_err;
        end
        wsfpu_pkg::PH_LEN16, wsfpu_pkg::PH_LEN64: begin
          if (len_done && len_too_big) begin
            err = wsfpu_pkg::ERR_SIZE;
          end
        end
        wsfpu_pkg::PH_MASK: begin
          if (mask_done && !ctrl && total_too_big) begin
            err = wsfpu_pkg::ERR_SIZE;
          end
        end
        wsfpu_pkg::PH_STUCK: begin
          err = err_latched;
        end
        default: begin
          err = wsfpu_pkg::ERR_NONE;
        end
      endcase
    end
    new_err = (err != wsfpu_pkg::ERR_NONE) && (phase != wsfpu_pkg::PH_STUCK);
  end

  // result beat
  always_comb begin
    result_next = '0;
    fend        = 1'b0;
    type_set    = 1'b0;
    if (item.mode) begin
      result_next.kind = wsfpu_pkg::KIND_OTHER;
    end else begin
      result_next.kind = wsfpu_pkg::KIND_HEADER;
      case (phase)
        wsfpu_pkg::PH_MASK: begin
          if (mask_done && !new_err) begin
            fend     = frame_length == '0;
            type_set = !ctrl && (op != wsfpu_pkg::OP_CONT);
          end
        end
        wsfpu_pkg::PH_BODY: begin
          result_next.kind         = wsfpu_pkg::KIND_PAYLOAD;
          result_next.payload_byte = b ^ mask_key[{key_sel, 3'b000} +: 8];
          fend                     = body_last;
        end
        wsfpu_pkg::PH_STUCK: begin
          result_next.kind = wsfpu_pkg::KIND_OTHER;
        end
        default: begin
          result_next.kind = wsfpu_pkg::KIND_HEADER;
        end
      endcase
      if (new_err) begin
        result_next.kind         = wsfpu_pkg::KIND_OTHER;
        result_next.payload_byte = 8'd0;
      end
      result_next.frame_opcode   = (phase == wsfpu_pkg::PH_HEAD0) ? b[3:0] : op;
      result_next.message_opcode = type_set ? op : message_type;
      result_next.is_control     = wsfpu_pkg::opcode_control(result_next.frame_opcode);
      result_next.frame_end      = fend;
      result_next.message_end    = fend && !ctrl &&
                                   ((first_header_byte & wsfpu_pkg::HDR_FIN_BIT) != 8'd0);
      result_next.error_code     = err;
    end
    msg_done = result_next.message_end;
  end

  // next state
  always_comb begin
    phase_next             = phase;
    first_header_byte_next = first_header_byte;
    frame_length_next      = frame_length;
    len_over_next          = len_over;
    byte_count_next        = byte_count;
    mask_key_next          = mask_key;
    message_total_next     = message_total;
    message_open_next      = message_open;
    message_type_next      = message_type;
    err_latched_next       = err_latched;
    if (item.mode) begin
      phase_next             = wsfpu_pkg::PH_HEAD0;
      first_header_byte_next = 8'd0;
      frame_length_next      = '0;
      len_over_next          = 1'b0;
      byte_count_next        = '0;
      message_total_next     = '0;
      message_open_next      = 1'b0;
      message_type_next      = 4'd0;
      err_latched_next       = wsfpu_pkg::ERR_NONE;
    end else begin
      case (phase)
        wsfpu_pkg::PH_HEAD0: begin
          first_header_byte_next = b;
          phase_next             = wsfpu_pkg::PH_HEAD1;
        end
        wsfpu_pkg::PH_HEAD1: begin
          if (head_err == wsfpu_pkg::ERR_NONE) begin
            byte_count_next = '0;
            len_over_next   = 1'b0;
            if (len7 == wsfpu_pkg::LEN7_EXT16) begin
              frame_length_next = '0;
              phase_next        = wsfpu_pkg::PH_LEN16;
            end else if (len7 == wsfpu_pkg::LEN7_EXT64) begin
              frame_length_next = '0;
              phase_next        = wsfpu_pkg::PH_LEN64;
            end else begin
              frame_length_next = LW'(len7);
              phase_next        = wsfpu_pkg::PH_MASK;
            end
          end
        end
        wsfpu_pkg::PH_LEN16, wsfpu_pkg::PH_LEN64: begin
          frame_length_next = len_shift[LW-1:0];
          len_over_next     = len_shift_over;
          byte_count_next   = byte_count_inc;
          if (len_done) begin
            byte_count_next = '0;
            if (!len_too_big) begin
              phase_next = wsfpu_pkg::PH_MASK;
            end
          end
        end
        wsfpu_pkg::PH_MASK: begin
          mask_key_next   = mask_key_upd;
          byte_count_next = byte_count_inc;
          if (mask_done) begin
            byte_count_next = '0;
            if (!new_err) begin
              if (!ctrl) begin
                message_total_next = total_sum[LW-1:0];
                message_open_next  = 1'b1;
              end
              if (type_set) begin
                message_type_next = op;
              end
              phase_next = fend ? wsfpu_pkg::PH_HEAD0 : wsfpu_pkg::PH_BODY;
            end
          end
        end
        wsfpu_pkg::PH_BODY: begin
          byte_count_next = byte_count_inc;
          if (body_last) begin
            byte_count_next = '0;
            phase_next      = wsfpu_pkg::PH_HEAD0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
      if (new_err) begin
        phase_next       = wsfpu_pkg::PH_STUCK;
        err_latched_next = err;
      end
      if (msg_done) begin
        message_open_next  = 1'b0;
        message_total_next = '0;
        message_type_next  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfpu_pkg::PH_HEAD0;
      first_header_byte <= 8'd0;
      frame_length      <= '0;
      len_over          <= 1'b0;
      byte_count        <= '0;
      mask_key          <= 32'd0;
      message_total     <= '0;
      message_open      <= 1'b0;
      message_type      <= 4'd0;
      err_latched       <= wsfpu_pkg::ERR_NONE;
    end else if (accept) begin
      phase             <= phase_next;
      first_header_byte <= first_header_byte_next;
      frame_length      <= frame_length_next;
      len_over          <= len_over_next;
      byte_count        <= byte_count_next;
      mask_key          <= mask_key_next;
      message_total     <= message_total_next;
      message_open      <= message_open_next;
      message_type      <= message_type_next;
      err_latched       <= err_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= wsfpu_pkg::MAX_MESSAGE_RESET;
    end else if (cfg_write) begin
      max_message_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  `WSFPU_ASSERT(a_stuck_has_code, clk, rst,
    (phase == wsfpu_pkg::PH_STUCK) |-> (err_latched != wsfpu_pkg::ERR_NONE),
    "stuck without a latched error")
  `WSFPU_ASSERT(a_open_has_type, clk, rst,
    message_open |-> (message_type != 4'd0),
    "open message without a type")
  `WSFPU_ASSERT(a_body_in_range, clk, rst,
    (phase == wsfpu_pkg::PH_BODY) |-> (byte_count < frame_length),
    "payload offset past frame length")
  `WSFPU_ASSERT_NEVER(a_err_kind, clk, rst,
    result_valid && (result.error_code != wsfpu_pkg::ERR_NONE) &&
    (result.kind != wsfpu_pkg::KIND_OTHER),
    "error beat with wrong kind")
  `WSFPU_ASSERT_NEVER(a_mend_fend, clk, rst,
    result_valid && result.message_end && !result.frame_end,
    "message end without frame end")

endmodule

`default_nettype wire

FILE: test/websocket_frame_parser_unmasker_core_test.sv
module websocket_frame_parser_unmasker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfpu_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 60;
  localparam int PHASE_BEATS = 275;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item_beat = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result_beat;
  logic cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;

  websocket_frame_parser_unmasker_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser mirror
  phase_t ph;
  logic [7:0] hdr0;
  logic [63:0] flen;
  logic [63:0] bcount;
  logic [31:0] mkey;
  logic [63:0] mtotal;
  logic mopen;
  logic [3:0] mtype;
  logic [2:0] err_held;
  logic [31:0] limit_bytes;

  item_t stream_bytes[$];
  result_t parsed_bytes_due[$];
  int mismatches = 0;
  int pushed = 0;
  int cap = 20;
  bit calm = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int quiet = 0;

  function automatic logic ctrl_op(input logic [3:0] op);
    return op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  function automatic logic known_op(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BINARY || ctrl_op(op);
  endfunction

  task automatic clear_parse_state();
    ph = PH_HEAD0;
    hdr0 = '0;
    flen = '0;
    bcount = '0;
    mtotal = '0;
    mopen = 1'b0;
    mtype = '0;
    err_held = ERR_NONE;
  endtask

  task automatic parse_ws_byte(input item_t it, output result_t r);
    logic [7:0] b;
    logic [6:0] len7;
    logic [3:0] op;
    logic [2:0] err;
    logic [1:0] kind;
    logic [7:0] pay;
    logic fend;
    logic mend;
    logic [63:0] lim;
    b = it.data_byte;
    err = ERR_NONE;
    kind = KIND_HEADER;
    pay = '0;
    fend = 1'b0;
    mend = 1'b0;
    lim = {32'd0, limit_bytes};
    if (it.mode) begin
      clear_parse_state();
      kind = KIND_OTHER;
    end else begin
      case (ph)
        PH_HEAD0: begin
          hdr0 = b;
          ph = PH_HEAD1;
        end
        PH_HEAD1: begin
          len7 = b[6:0];
          op = hdr0[3:0];
          if ((hdr0 & HDR_RSV_BITS) != 0) err = ERR_RESERVED;
          else if ((b & HDR_MASK_BIT) == 0) err = ERR_UNMASKED;
          else if (!known_op(op)) err = ERR_OPCODE;
          else if (!ctrl_op(op) && ((op != OP_CONT) == mopen)) err = ERR_SEGMENT;
          else if ({57'd0, len7} > lim) err = ERR_SIZE;
          else begin
            bcount = '0;
            flen = '0;
            if (len7 == LEN7_EXT16) ph = PH_LEN16;
            else if (len7 == LEN7_EXT64) ph = PH_LEN64;
            else begin
              flen = {57'd0, len7};
              ph = PH_MASK;
            end
          end
        end
        PH_LEN16, PH_LEN64: begin
          flen = {flen[55:0], b};
          bcount++;
          if (bcount >= (ph == PH_LEN16 ? LEN16_BYTES : LEN64_BYTES)) begin
            bcount = '0;
            if (flen > lim) err = ERR_SIZE;
            else ph = PH_MASK;
          end
        end
        PH_MASK: begin
          mkey[8 * bcount[1:0] +: 8] = b;
          bcount++;
          if (bcount >= MASK_BYTES) begin
            bcount = '0;
            op = hdr0[3:0];
            if (!ctrl_op(op) && (mtotal + flen > lim)) begin
              err = ERR_SIZE;
            end else begin
              if (!ctrl_op(op)) begin
                mtotal = mtotal + flen;
                if (op != OP_CONT) mtype = op;
                mopen = 1'b1;
              end
              if (flen == 0) begin
                fend = 1'b1;
                ph = PH_HEAD0;
              end else begin
                ph = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          kind = KIND_PAYLOAD;
          pay = b ^ mkey[8 * bcount[1:0] +: 8];
          bcount++;
          if (bcount >= flen) begin
            bcount = '0;
            fend = 1'b1;
            ph = PH_HEAD0;
          end
        end
        default: begin
          kind = KIND_OTHER;
          err = err_held;
        end
      endcase
      if (err != ERR_NONE && ph != PH_STUCK) begin
        ph = PH_STUCK;
        err_held = err;
        kind = KIND_OTHER;
        pay = '0;
        fend = 1'b0;
      end
      if (fend && !ctrl_op(hdr0[3:0]) && (hdr0 & HDR_FIN_BIT) != 0) mend = 1'b1;
    end
    r.kind = kind;
    r.payload_byte = pay;
    r.frame_opcode = hdr0[3:0];
    r.message_opcode = mtype;
    r.is_control = ctrl_op(hdr0[3:0]);
    r.frame_end = fend;
    r.message_end = mend;
    r.error_code = err;
    if (mend) begin
      mopen = 1'b0;
      mtotal = '0;
      mtype = '0;
    end
  endtask

  function automatic string show(input result_t r);
    return $sformatf("kind %0d byte %02h fop %h mop %h ctl %b fend %b mend %b err %0d",
                     r.kind, r.payload_byte, r.frame_opcode, r.message_opcode,
                     r.is_control, r.frame_end, r.message_end, r.error_code);
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // sender
  always @(posedge clk) begin : drive_bytes
    item_t nxt_item;
    logic nxt_valid;
    result_t due;
    nxt_item = item_beat;
    nxt_valid = item_valid;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        parse_ws_byte(item_beat, due);
        parsed_bytes_due.push_back(due);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stream_bytes.size() != 0) begin
          if (!calm && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(0, 12);
          end else begin
            nxt_item = stream_bytes.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
    end
    item_valid <= nxt_valid;
    item_beat <= nxt_item;
  end

  // receiver and checker
  always @(posedge clk) begin : check_results
    result_t want;
    logic nxt_stall;
    if (!rst && result_valid && !result_stall) begin
      if (parsed_bytes_due.size() == 0) begin
        note_failure({"unexpected beat: ", show(result_beat)});
      end else begin
        want = parsed_bytes_due.pop_front();
        if (result_beat.kind !== want.kind || result_beat.payload_byte !== want.payload_byte ||
            result_beat.frame_opcode !== want.frame_opcode ||
            result_beat.message_opcode !== want.message_opcode ||
            result_beat.is_control !== want.is_control ||
            result_beat.frame_end !== want.frame_end ||
            result_beat.message_end !== want.message_end ||
            result_beat.error_code !== want.error_code)
          note_failure({"mismatch: expected ", show(want), " got ", show(result_beat)});
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      recv_hold = LONG_HOLD;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      nxt_stall = 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      recv_hold = $urandom_range(0, 12);
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = 1'b0;
    end
    result_stall <= nxt_stall;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus
  task automatic push_beat(input logic mode, input logic [7:0] b);
    item_t it;
    it.mode = mode;
    it.data_byte = b;
    stream_bytes.push_back(it);
    pushed++;
  endtask

  task automatic push_clear();
    push_beat(1'b1, 8'($urandom));
  endtask

  task automatic push_frame(input logic [7:0] b0, input logic masked, input logic [63:0] len,
                            input int enc, input int body);
    logic [6:0] len7;
    len7 = (enc == 1) ? LEN7_EXT16 : (enc == 2) ? LEN7_EXT64 : len[6:0];
    push_beat(1'b0, b0);
    push_beat(1'b0, {masked, len7});
    if (enc == 1) begin
      push_beat(1'b0, len[15:8]);
      push_beat(1'b0, len[7:0]);
    end
    if (enc == 2) for (int i = 7; i >= 0; i--) push_beat(1'b0, len[8 * i +: 8]);
    repeat (MASK_BYTES) push_beat(1'b0, 8'($urandom));
    repeat (body) push_beat(1'b0, 8'($urandom));
  endtask

  function automatic int pick_enc(input logic [63:0] len);
    int r;
    r = $urandom_range(0, 11);
    if (len > 65535) return 2;
    if (len > 125) return (r < 6) ? 1 : 2;
    return (r == 0) ? 2 : (r < 3) ? 1 : 0;
  endfunction

  task automatic control_frame();
    logic [3:0] op;
    logic [63:0] len;
    case ($urandom_range(0, 2))
      0: op = OP_CLOSE;
      1: op = OP_PING;
      default: op = OP_PONG;
    endcase
    len = $urandom_range(0, cap);
    push_frame({1'($urandom), 3'b000, op}, 1'b1, len, pick_enc(len), int'(len));
  endtask

  task automatic data_message();
    int nfrag;
    logic [3:0] op;
    logic [63:0] len;
    nfrag = $urandom_range(1, 4);
    for (int f = 0; f < nfrag; f++) begin
      if ($urandom_range(0, 3) == 0) control_frame();
      op = (f != 0) ? OP_CONT : $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
      len = $urandom_range(0, cap);
      if (limit_bytes >= 300 && $urandom_range(0, 29) == 0) len = $urandom_range(126, 300);
      push_frame({f == nfrag - 1, 3'b000, op}, 1'b1, len, pick_enc(len), int'(len));
    end
  endtask

  task automatic oversize_frame();
    logic [63:0] len;
    logic [63:0] half;
    case ($urandom_range(0, 2))
      0: begin
        len = {32'd0, limit_bytes} + 64'($urandom_range(1, 4));
        push_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, len, pick_enc(len), 3);
      end
      1: begin
        len = {32'($urandom), 32'($urandom)};
        push_frame({1'($urandom), 3'b000, OP_TEXT}, 1'b1, len, 2, 3);
      end
      default: begin
        // two fragments that may overflow together
        half = {33'd0, limit_bytes[31:1]} + 1;
        if (half > 40) half = 40;
        push_frame({1'b0, 3'b000, OP_TEXT}, 1'b1, half, pick_enc(half), int'(half));
        push_frame({1'b1, 3'b000, OP_CONT}, 1'b1, half, pick_enc(half), int'(half));
      end
    endcase
    push_clear();
  endtask

  task automatic broken_frame();
    logic [3:0] op;
    case ($urandom_range(0, 5))
      0: begin
        push_beat(1'b0, 8'($urandom));
        push_beat(1'b0, 8'($urandom));
        repeat ($urandom_range(0, 8)) push_beat(1'b0, 8'($urandom));
      end
      1: push_frame({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)}, 1'b1, 2, 0, 2);
      2: push_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, 2, 0, 2);
      3: begin
        op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        push_frame({1'($urandom), 3'b000, op}, 1'b1, 1, 0, 1);
      end
      4: push_frame({1'($urandom), 3'b000, OP_CONT}, 1'b1, 1, 0, 1);
      default: begin
        push_frame({1'b0, 3'b000, OP_BINARY}, 1'b1, 0, 0, 0);
        push_frame({1'($urandom), 3'b000, OP_TEXT}, 1'b1, 1, 0, 1);
      end
    endcase
    push_clear();
  endtask

  task automatic random_phase(input int goal);
    int stop;
    int r;
    stop = pushed + goal;
    while (pushed < stop) begin
      r = $urandom_range(0, 19);
      if (r < 14) data_message();
      else if (r < 16) control_frame();
      else if (r == 16) oversize_frame();
      else if (r < 19) broken_frame();
      else push_clear();
      if ($urandom_range(0, 5) == 0) push_clear();
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (stream_bytes.size() != 0 || item_valid || parsed_bytes_due.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    limit_bytes = v;
    cap = (v >= 100) ? 20 : int'(v / 5);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] limits[5];
    limits = '{32'd64, 32'hFFFF_FFFF, 32'd0, 32'd300, MAX_MESSAGE_RESET};
    clear_parse_state();
    mkey = '0;
    limit_bytes = MAX_MESSAGE_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short directed opening under the reset limit
    push_clear();
    push_beat(1'b0, 8'hF1);
    push_beat(1'b0, 8'h81);
    push_beat(1'b0, 8'hFF);
    push_clear();
    push_beat(1'b0, {1'b1, 3'b000, OP_TEXT});
    push_beat(1'b0, 8'h05);
    push_clear();
    push_beat(1'b0, {1'b1, 3'b000, 4'h3});
    push_beat(1'b0, 8'h80);
    push_clear();
    push_beat(1'b0, {1'b1, 3'b000, OP_CONT});
    push_beat(1'b0, 8'h80);
    push_clear();
    push_frame({1'b0, 3'b000, OP_TEXT}, 1'b1, 1, 0, 1);
    push_beat(1'b0, {1'b1, 3'b000, OP_BINARY});
    push_beat(1'b0, 8'h80);
    push_clear();
    push_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 0, 0, 0);

    for (int k = 0; k < 5; k++) begin
      wait_drain();
      write_limit(limits[k]);
      if (k == 4) calm = 1'b1;
      random_phase(PHASE_BEATS);
      // long receiver hold while the sender keeps offering
      if (k == 1) hold_req++;
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && parsed_bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
